// ----- rtl/dte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dte_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 16;

    localparam logic [1:0] ACT_REMEMBER = 2'd0;
    localparam logic [1:0] ACT_FORGET   = 2'd1;
    localparam logic [1:0] ACT_CHECK    = 2'd2;
    localparam logic [1:0] ACT_PURGE    = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [31:0] data;
        logic [63:0] expiry;
    } t_slot;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/dte_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dte_cell (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_shift,
    input  wire dte_pkg::t_slot i_slot,
    output dte_pkg::t_slot o_slot
);
    import dte_pkg::*;

    logic        r_valid;
    logic [63:0] r_key;
    logic [31:0] r_data;
    logic [63:0] r_expiry;

    // valid is control state; key, data and expiry need no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key    <= i_slot.key;
            r_data   <= i_slot.data;
            r_expiry <= i_slot.expiry;
        end
    end

    assign o_slot.valid  = r_valid;
    assign o_slot.key    = r_key;
    assign o_slot.data   = r_data;
    assign o_slot.expiry = r_expiry;

endmodule
`default_nettype wire

// ----- rtl/dedup_table_with_expiry_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | tdata (low bit up)                        | tuser (low bit up)
// s       | in        | msg_key, data_in, expire_time, now_time   | action
// m       | out       | data_out, evicted_key, evicted_data,      | is_duplicate, evicted,
//         |           | next_expiry                               | table_full ; tlast = last
//
// The slots sit in a ring of cells that rotates one place a cycle while a request is
// worked on; the head cell is examined and rewritten as it passes. Forget, check and
// purge make one lap, then load the final result; remember makes a search lap, then a
// write lap unless the table is full, then loads the result. The input is ready again
// once the result is loaded. Purge holds the ring while an eviction waits for the
// output register. Reset is synchronous and clears every slot's valid bit at once.
module dedup_table_with_expiry_core #(
    parameter int unsigned TABLE_ENTRIES = dte_pkg::TABLE_ENTRIES_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [223:0] i_s_tdata,  // msg_key, data_in, expire_time, now_time
    input  wire  [1:0]   i_s_tuser,  // action
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [191:0] o_m_tdata,  // data_out, evicted_key, evicted_data, next_expiry
    output logic [2:0]   o_m_tuser,  // is_duplicate, evicted, table_full
    output logic         o_m_tlast
);
    import dte_pkg::*;

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;
    logic [IW-1:0] r_cnt;
    logic [1:0]  r_act;
    logic [63:0] r_key, r_exp, r_now;
    logic [31:0] r_data;
    // search results of the remember lap
    logic r_hit, n_hit, r_free, n_free;
    logic [IW-1:0] r_hit_idx, n_hit_idx, r_free_idx, n_free_idx, r_tgt;
    // pending final result
    logic        r_dup, n_dup, r_ev, n_ev, r_full, n_full;
    logic [31:0] r_dout, n_dout, r_evd, n_evd;
    logic [63:0] r_evk, n_evk, r_next, n_next;
    // output register
    logic         r_ov;
    logic [191:0] r_od;
    logic [2:0]   r_ou;
    logic         r_ol;

    t_slot w_slot [TABLE_ENTRIES];
    t_slot w_wb;
    logic  w_step, w_emit, w_emit_last, w_can_emit, w_match, w_expd, w_accept;
    logic [191:0] w_ed;
    logic [2:0]   w_eu;

    // ring: each cell takes its upper neighbour, the top cell takes the written-back head
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        dte_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(w_step),
            .i_slot ((g == TABLE_ENTRIES - 1) ? w_wb : w_slot[(g + 1) % TABLE_ENTRIES]),
            .o_slot (w_slot[g])
        );
    end

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_can_emit = !r_ov || i_m_tready;
    assign w_match    = w_slot[0].valid && (w_slot[0].key == r_key);
    assign w_expd     = w_slot[0].expiry <= r_now;

    always_comb begin
        n_state = r_state;
        w_wb = w_slot[0];
        w_step = 1'b0;
        w_emit = 1'b0;
        w_emit_last = 1'b0;
        w_ed = '0;
        w_eu = '0;
        n_hit = r_hit; n_hit_idx = r_hit_idx;
        n_free = r_free; n_free_idx = r_free_idx;
        n_dup = r_dup; n_dout = r_dout; n_ev = r_ev; n_evk = r_evk; n_evd = r_evd;
        n_next = r_next; n_full = r_full;
        o_s_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_step = 1'b1;
                case (r_act)
                    ACT_REMEMBER: begin
                        if (w_match) begin
                            n_hit = 1'b1;
                            n_hit_idx = r_cnt;
                        end
                        if (!w_slot[0].valid && !r_free) begin
                            n_free = 1'b1;
                            n_free_idx = r_cnt;
                        end
                    end
                    ACT_FORGET: begin
                        if (w_match) begin
                            w_wb.valid = 1'b0;
                        end
                    end
                    ACT_CHECK: begin
                        if (w_match) begin
                            if (w_expd) begin
                                w_wb.valid = 1'b0;
                                n_ev = 1'b1;
                                n_evk = w_slot[0].key;
                                n_evd = w_slot[0].data;
                            end else begin
                                n_dup = 1'b1;
                                n_dout = w_slot[0].data;
                            end
                        end
                    end
                    ACT_PURGE: begin
                        if (w_slot[0].valid && w_expd) begin
                            // hold the ring until the eviction can be transferred
                            w_step = w_can_emit;
                            w_emit = w_can_emit;
                            w_wb.valid = 1'b0;
                            w_ed = {64'd0, w_slot[0].data, w_slot[0].key, 32'd0};
                            w_eu = 3'b010;
                        end else if (w_slot[0].valid &&
                                     (r_next == 64'd0 || w_slot[0].expiry < r_next)) begin
                            n_next = w_slot[0].expiry;
                        end
                    end
                    default: ;
                endcase
                if (w_step && r_cnt == LAST_IDX) begin
                    if (r_act == ACT_REMEMBER) begin
                        if (n_hit || n_free) begin
                            n_state = ST_WRITE;
                        end else begin
                            n_full = 1'b1;
                            n_state = ST_DONE;
                        end
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WRITE: begin
                w_step = 1'b1;
                if (r_cnt == r_tgt) begin
                    w_wb.valid = 1'b1;
                    w_wb.key = r_key;
                    w_wb.data = r_data;
                    w_wb.expiry = r_exp;
                end
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    w_emit_last = 1'b1;
                    w_ed = {r_next, r_evd, r_evk, r_dout};
                    w_eu = {r_full, r_ev, r_dup};
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (w_step) begin
                r_cnt <= (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload and per-item bookkeeping
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_s_tuser;
            r_key <= i_s_tdata[63:0];
            r_data <= i_s_tdata[95:64];
            r_exp <= i_s_tdata[159:96];
            r_now <= i_s_tdata[223:160];
            r_hit <= 1'b0; r_free <= 1'b0;
            r_dup <= 1'b0; r_dout <= '0; r_ev <= 1'b0; r_evk <= '0; r_evd <= '0;
            r_next <= '0; r_full <= 1'b0;
        end else begin
            r_hit <= n_hit; r_hit_idx <= n_hit_idx;
            r_free <= n_free; r_free_idx <= n_free_idx;
            r_tgt <= n_hit ? n_hit_idx : n_free_idx;
            r_dup <= n_dup; r_dout <= n_dout; r_ev <= n_ev; r_evk <= n_evk;
            r_evd <= n_evd; r_next <= n_next; r_full <= n_full;
        end
        if (w_emit) begin
            r_od <= w_ed;
            r_ou <= w_eu;
            r_ol <= w_emit_last;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tuser  = r_ou;
    assign o_m_tlast  = r_ol;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import dte_pkg::*;

    localparam int unsigned NSLOTS     = TABLE_ENTRIES_DEF;
    localparam int unsigned IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
        logic [31:0] data;
        logic [63:0] expire;
        logic [63:0] now;
    } t_req;

    typedef struct packed {
        logic        dup;
        logic [31:0] dout;
        logic        ev;
        logic [63:0] evk;
        logic [31:0] evd;
        logic [63:0] nxt;
        logic        full;
        logic        lst;
    } t_resp;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [223:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    logic         s_tready, m_tvalid, m_tlast;
    logic [191:0] m_tdata;
    logic [2:0]   m_tuser;

    dedup_table_with_expiry_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser), .o_m_tlast(m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the table
    logic        shadow_valid [NSLOTS];
    logic [63:0] shadow_key   [NSLOTS];
    logic [31:0] shadow_data  [NSLOTS];
    logic [63:0] shadow_exp   [NSLOTS];

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    t_req  cur_req;
    logic  s_taken = 1'b0;
    int    send_gap = 0, stall_gap = 0;
    int    idle_cycles = 0;
    bit    failed = 1'b0;
    bit    no_idle = 1'b0;
    logic [63:0] key_pool [24];
    logic [63:0] clock_ms;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_resp blank_resp();
        t_resp r;
        r = '0;
        r.lst = 1'b1;
        return r;
    endfunction

    function automatic int lookup(logic [63:0] k);
        for (int i = 0; i < NSLOTS; i++)
            if (shadow_valid[i] && shadow_key[i] == k) return i;
        return -1;
    endfunction

    // work out the results of one accepted request and update the shadow table
    task automatic predict_dedup(t_req q);
        int s;
        t_resp r;
        logic [63:0] soonest;
        r = blank_resp();
        s = lookup(q.key);
        case (q.action)
            ACT_REMEMBER: begin
                if (s < 0)
                    for (int i = 0; i < NSLOTS; i++)
                        if (!shadow_valid[i]) begin
                            s = i;
                            break;
                        end
                if (s < 0) begin
                    r.full = 1'b1;
                end else begin
                    shadow_valid[s] = 1'b1;
                    shadow_key[s]   = q.key;
                    shadow_data[s]  = q.data;
                    shadow_exp[s]   = q.expire;
                end
                expected_resps.push_back(r);
            end
            ACT_FORGET: begin
                if (s >= 0) shadow_valid[s] = 1'b0;
                expected_resps.push_back(r);
            end
            ACT_CHECK: begin
                if (s >= 0) begin
                    if (shadow_exp[s] <= q.now) begin
                        shadow_valid[s] = 1'b0;
                        r.ev  = 1'b1;
                        r.evk = shadow_key[s];
                        r.evd = shadow_data[s];
                    end else begin
                        r.dup  = 1'b1;
                        r.dout = shadow_data[s];
                    end
                end
                expected_resps.push_back(r);
            end
            default: begin
                soonest = '0;
                for (int i = 0; i < NSLOTS; i++) begin
                    if (!shadow_valid[i]) continue;
                    if (shadow_exp[i] <= q.now) begin
                        shadow_valid[i] = 1'b0;
                        r = '0;
                        r.ev  = 1'b1;
                        r.evk = shadow_key[i];
                        r.evd = shadow_data[i];
                        expected_resps.push_back(r);
                    end else if (soonest == 0 || shadow_exp[i] < soonest) begin
                        soonest = shadow_exp[i];
                    end
                end
                r = blank_resp();
                r.nxt = soonest;
                expected_resps.push_back(r);
            end
        endcase
    endtask

    // driver: advance to the next request at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || s_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                s_tdata  <= {cur_req.now, cur_req.expire, cur_req.data, cur_req.key};
                s_tuser  <= cur_req.action;
                s_tvalid <= 1'b1;
                send_gap <= draw_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        if (i_rst_n) begin
            if (stall_gap > 0) begin
                stall_gap <= stall_gap - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready  <= 1'b1;
                stall_gap <= draw_gap();
            end
        end
    end

    // monitor: record input transfers, check output transfers
    always @(posedge i_clk) begin
        t_resp got, want;
        s_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) predict_dedup(cur_req);
        if (m_tvalid && m_tready) begin
            got.dup  = m_tuser[0];
            got.dout = m_tdata[31:0];
            got.ev   = m_tuser[1];
            got.evk  = m_tdata[95:32];
            got.evd  = m_tdata[127:96];
            got.nxt  = m_tdata[191:128];
            got.full = m_tuser[2];
            got.lst  = m_tlast;
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                failed = 1'b1;
            end else begin
                want = expected_resps.pop_front();
                if (got !== want) begin
                    $display("%0t: expected %h actual %h", $time, want, got);
                    failed = 1'b1;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("dedup_table_with_expiry_core: mismatch");
            $finish;
        end
    end

    task automatic queue_req(logic [1:0] a, logic [63:0] k, logic [31:0] d,
                             logic [63:0] e, logic [63:0] n);
        t_req q;
        q.action = a;
        q.key    = k;
        q.data   = d;
        q.expire = e;
        q.now    = n;
        pending_reqs.push_back(q);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        int r;
        logic [63:0] k;
        for (int i = 0; i < NSLOTS; i++) shadow_valid[i] = 1'b0;
        for (int i = 0; i < 24; i++) key_pool[i] = (i < 12) ? 64'(i) : rand64();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, equality expiry, unknown keys, full table, purges
        queue_req(ACT_CHECK, '1, '0, '0, '0);
        queue_req(ACT_FORGET, '1, '1, '1, '1);
        queue_req(ACT_REMEMBER, '1, '1, '1, 64'd5);
        queue_req(ACT_CHECK, '1, '0, '0, 64'd5);
        queue_req(ACT_CHECK, '1, '0, '0, '1);
        queue_req(ACT_REMEMBER, '0, 32'h5a5a_a5a5, 64'd100, '0);
        queue_req(ACT_CHECK, '0, '0, '0, 64'd100);
        for (int i = 0; i < NSLOTS; i++)
            queue_req(ACT_REMEMBER, 64'(i + 16), $urandom(), 64'(100 * (i + 1)), '0);
        queue_req(ACT_REMEMBER, 64'hdead_beef, $urandom(), 64'd7, '0);
        queue_req(ACT_REMEMBER, 64'd20, 32'h1234_5678, '1, '0);
        queue_req(ACT_FORGET, 64'd17, '0, '0, '0);
        queue_req(ACT_PURGE, '0, '0, '0, 64'd800);
        queue_req(ACT_PURGE, '0, '0, '0, '1);
        queue_req(ACT_PURGE, '0, '0, '0, '0);

        // random: mostly a rising clock with short lifetimes and a small key pool
        clock_ms = 64'd1000;
        for (int n = 0; n < 250; n++) begin
            no_idle = (n / 40) % 3 == 2;
            clock_ms += $urandom_range(0, 20);
            r = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, 23)];
            if ($urandom_range(0, 19) == 0) k = rand64();
            if (r < 40)
                queue_req(ACT_REMEMBER, k, $urandom(),
                          ($urandom_range(0, 9) == 0) ? rand64()
                                                      : clock_ms + $urandom_range(0, 150),
                          clock_ms);
            else if (r < 55)
                queue_req(ACT_FORGET, k, $urandom(), rand64(), clock_ms);
            else if (r < 87)
                queue_req(ACT_CHECK, k, $urandom(), rand64(),
                          ($urandom_range(0, 14) == 0) ? rand64() : clock_ms);
            else
                queue_req(ACT_PURGE, rand64(), $urandom(), rand64(),
                          ($urandom_range(0, 9) == 0) ? rand64() : clock_ms);
        end

        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_resps.size() == 0);
        repeat (60) @(posedge i_clk);
        if (!failed && expected_resps.size() == 0) begin
            $display("dedup_table_with_expiry_core: match");
        end else begin
            $display("dedup_table_with_expiry_core: mismatch");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/dte_pkg.sv
rtl/dte_cell.sv
rtl/dedup_table_with_expiry_core.sv
tb/tb.sv
